// ===== hdl/smdl_pkg.sv =====
// Shared types, field layout and default constants of the switch matrix debouncer.
package smdl_pkg;

	// Default matrix geometry and time width
	localparam int ROWS_DEF      = 8;
	localparam int COLS_DEF      = 7;
	localparam int TIME_BITS_DEF = 32;

	// Configuration register
	localparam int              DEB_W          = 16;
	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

	// Input beat fields
	localparam int KIND_W  = 2;
	localparam int ROW_W   = 3;
	localparam int LEVEL_W = 7;
	localparam int NOW_W   = 32;
	localparam int IDX_W   = 6;

	localparam int ROW_LSB   = 0;
	localparam int LEVEL_LSB = ROW_LSB + ROW_W;
	localparam int NOW_LSB   = LEVEL_LSB + LEVEL_W;
	localparam int IDX_LSB   = NOW_LSB + NOW_W;
	localparam int IN_DATA_W = IDX_LSB + IDX_W;

	// Output beat fields
	localparam int STATE_W    = 7;
	localparam int OUT_DATA_W = STATE_W + 1;

	// Item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_SCAN = 2'd0,
		KIND_READ = 2'd1,
		KIND_RISE = 2'd2,
		KIND_FALL = 2'd3
	} kind_t;

endpackage

// ===== hdl/smdl_row_mem.sv =====
// Row memory holding raw levels and change stamps, with per-row valid bits.
module smdl_row_mem #(
	parameter int ROWS = 8,
	parameter int AW   = 3,
	parameter int EW   = 231
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [EW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [EW-1:0] wr_data
);

	logic [EW-1:0]   mem [ROWS];
	logic [EW-1:0]   rd_data_q;
	logic            rd_hit_q;
	logic [ROWS-1:0] valid_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Track written rows; an unwritten row reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

// ===== hdl/smdl_row_eval.sv =====
// Per-column debounce evaluation of one matrix row.
module smdl_row_eval
	import smdl_pkg::*;
#(
	parameter int COLS      = 7,
	parameter int TIME_BITS = 32
) (
	input  logic [COLS*(TIME_BITS+1)-1:0] entry,
	input  logic [COLS-1:0]               levels,
	input  logic [TIME_BITS-1:0]          now,
	input  logic [DEB_W-1:0]              debounce_ms,
	output logic [COLS*(TIME_BITS+1)-1:0] new_entry,
	output logic [COLS-1:0]               result
);

	localparam int CW = (TIME_BITS > DEB_W) ? TIME_BITS : DEB_W;

	// Evaluate each switch of the row side by side
	for (genvar c = 0; c < COLS; c++) begin : g_col
		logic [TIME_BITS-1:0] stamp;
		logic [TIME_BITS-1:0] elapsed;
		logic                 changed;

		assign stamp   = entry[COLS + c*TIME_BITS +: TIME_BITS];
		assign changed = levels[c] ^ entry[c];
		assign elapsed = now - stamp;

		// Raw bit follows the level; stamp restarts on a change
		assign new_entry[c] = levels[c];
		assign new_entry[COLS + c*TIME_BITS +: TIME_BITS] = changed ? now : stamp;

		assign result[c] = !changed && levels[c] &&
			(CW'(elapsed) > CW'(debounce_ms));
	end

endmodule

// ===== hdl/switch_matrix_debounce_latch_unit.sv =====
// Top level of the switch matrix debouncer: pipeline, state bits and stream ports.
// Path: an accepted beat is registered in stage one, then in the output register.
// Throughput: one beat per cycle while the output is not stalled; a scan reads its row
// from the row memory at accept and writes it back when it leaves stage one, a
// forwarding register covers back-to-back scans of the same row.
// Reset: debounce threshold returns to 20 ms, all debounced and latch bits clear,
// row memory (raw bits, stamps) reads zero through per-row valid bits; no clearing pass.
module switch_matrix_debounce_latch_unit
	import smdl_pkg::*;
#(
	parameter int ROWS      = ROWS_DEF,
	parameter int COLS      = COLS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [DEB_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // row[2:0], col_levels[9:3], now_ms[41:10],
	                                        // switch_index[47:42]
	input  logic [KIND_W-1:0]     s_tuser,  // kind[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // row_state[6:0], read_bit[7]
);

	localparam int NSW = ROWS * COLS;
	localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IW  = (NSW > 1) ? $clog2(NSW) : 1;
	localparam int EW  = COLS * (TIME_BITS + 1);

	logic [DEB_W-1:0] deb_ms_q;

	logic             accept;
	logic [ROW_W-1:0] in_row;

	logic                 s1_valid_q;
	logic                 s1_adv;
	kind_t                kind_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [LEVEL_W-1:0]   level_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [IDX_W-1:0]     idx_s1;

	logic [EW-1:0]   rd_data;
	logic [EW-1:0]   entry;
	logic [EW-1:0]   new_entry;
	logic [COLS-1:0] row_res;
	logic            row_ok;
	logic            scan_wr;

	logic            fwd_valid_q;
	logic [RAW-1:0]  fwd_row_q;
	logic [EW-1:0]   fwd_data_q;

	logic [NSW-1:0] deb_q;
	logic [NSW-1:0] latch_q;
	logic           sw_ok;
	logic           cur_bit;
	logic           cur_latch;
	logic           sense;
	logic           ans;
	logic           latch_wr;
	logic [STATE_W-1:0] row_state;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Hold the debounce threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_ms_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			deb_ms_q <= cfg_wdata;
		end
	end

	// Accept a beat whenever stage one is free or moving on
	assign s1_adv   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign accept   = s_tvalid && s_tready;
	assign in_row   = s_tdata[ROW_LSB +: ROW_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_t'(s_tuser);
			row_s1   <= in_row;
			level_s1 <= s_tdata[LEVEL_LSB +: LEVEL_W];
			now_s1   <= s_tdata[NOW_LSB +: TIME_BITS];
			idx_s1   <= s_tdata[IDX_LSB +: IDX_W];
		end
	end

	// Row memory, read at accept, written back when the scan leaves stage one
	smdl_row_mem #(
		.ROWS (ROWS),
		.AW   (RAW),
		.EW   (EW)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_row[RAW-1:0]),
		.rd_data (rd_data),
		.wr_en   (scan_wr),
		.wr_addr (row_s1[RAW-1:0]),
		.wr_data (new_entry)
	);

	// Forward the last written row over the stale memory read
	assign entry = (fwd_valid_q && fwd_row_q == row_s1[RAW-1:0]) ? fwd_data_q : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (scan_wr) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_wr) begin
			fwd_row_q  <= row_s1[RAW-1:0];
			fwd_data_q <= new_entry;
		end
	end

	smdl_row_eval #(
		.COLS      (COLS),
		.TIME_BITS (TIME_BITS)
	) u_row_eval (
		.entry       (entry),
		.levels      (COLS'(level_s1)),
		.now         (now_s1),
		.debounce_ms (deb_ms_q),
		.new_entry   (new_entry),
		.result      (row_res)
	);

	assign row_ok  = {1'b0, row_s1} < (ROW_W+1)'(ROWS);
	assign scan_wr = s1_adv && kind_s1 == KIND_SCAN && row_ok;

	// Look up the addressed switch
	assign sw_ok     = {1'b0, idx_s1} < (IDX_W+1)'(NSW);
	assign cur_bit   = deb_q[idx_s1[IW-1:0]];
	assign cur_latch = latch_q[idx_s1[IW-1:0]];
	assign sense     = (kind_s1 == KIND_RISE) ? cur_bit : !cur_bit;

	always_comb begin
		unique case (kind_s1)
			KIND_SCAN: ans = 1'b0;
			KIND_READ: ans = sw_ok && cur_bit;
			KIND_RISE,
			KIND_FALL: ans = sw_ok && sense && !cur_latch;
			default:   ans = 1'b0;
		endcase
	end

	assign latch_wr  = s1_adv && sw_ok && (kind_s1 == KIND_RISE || kind_s1 == KIND_FALL);
	assign row_state = (kind_s1 == KIND_SCAN && row_ok) ? STATE_W'(row_res) : '0;

	// Replace the scanned row's debounced bits and update edge latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q   <= '0;
			latch_q <= '0;
		end else begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					if (scan_wr && row_s1 == ROW_W'(r)) begin
						deb_q[r*COLS + c] <= row_res[c];
					end
				end
			end
			if (latch_wr) begin
				latch_q[idx_s1[IW-1:0]] <= sense;
			end
		end
	end

	// Output register, held until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= {ans, row_state};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A stalled stage one keeps its beat
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q)
		else $error("stage one beat lost while stalled");

	// A beat never carries both a row state and a read answer
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[STATE_W-1:0] != '0 |-> !m_tdata[STATE_W])
		else $error("row state and read answer both set");

	// The forwarding register tracks each write-back
	assert property (@(posedge clk) disable iff (!arst_n)
		scan_wr |=> fwd_valid_q && fwd_row_q == $past(row_s1[RAW-1:0]))
		else $error("forwarding register missed a write-back");

	// Latches change only on a latched read
	assert property (@(posedge clk) disable iff (!arst_n)
		!latch_wr |=> $stable(latch_q))
		else $error("edge latch changed without a latched read");

	// Debounced bits change only on a scan write-back
	assert property (@(posedge clk) disable iff (!arst_n)
		!scan_wr |=> $stable(deb_q))
		else $error("debounced bits changed without a scan");

endmodule
